### src/npt_pkg.sv
`default_nettype none

package npt_pkg;

	// Width of the running near-prime count and of the near_total field.
	localparam int unsigned COUNT_W = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Output stream: above_is_prime, below_is_prime, is_near_prime, near_total.
	localparam int unsigned OUT_BITS = 3 + COUNT_W;
	localparam int unsigned OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input value
		logic init_cand;  // form a candidate, restart the divisor at two
		logic below;      // candidate is value-1 (else value+1)
		logic start_div;  // load the divider with the candidate
		logic div_step;   // one restoring division step
		logic advance;    // move to the next trial divisor
		logic mark;       // record the prime flag of the current candidate
		logic prime;      // flag value to record
		logic finish;     // update the count and the output flags
	} npt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic low_cand;   // candidate is 1 or less
		logic sq_gt;      // divisor squared exceeds the candidate
		logic div_last;   // the division is on its final step
		logic rem_zero;   // remainder of the finished division is zero
	} npt_stat_t;

endpackage

`default_nettype wire

### src/near_prime_tester.sv
// Near-prime tester.
// Each input transaction on the s_ stream carries one signed value. The block
// tests value+1 and value-1 for primality by trial division and returns one
// result transaction on the m_ stream: both prime flags, their OR, and the
// running count of near-prime items including this one (saturating at all ones).
// Items are processed one at a time. Each neighbor is tested against its trial
// divisors in turn: the divider is a restoring unit that retires one dividend
// bit per cycle.
// s_tready is high only while the block is idle.
// The result sits in an output register, so the next item is accepted while it
// waits; if the receiver holds m_tready low, the block finishes that next item
// and then waits until the previous result is taken.
// Reset clears the count, drops m_tvalid and returns the block to idle.
`default_nettype none

module near_prime_tester #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// value (two's complement; low VALUE_WIDTH bits used)
	input  wire  [((((VALUE_WIDTH > 32) ? VALUE_WIDTH : 32) + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// above_is_prime, below_is_prime, is_near_prime, near_total, zero fill
	output logic [npt_pkg::OUT_W-1:0]        m_tdata
);
	import npt_pkg::*;

	npt_cmd_t  cmd;
	npt_stat_t stat;

	logic               above_is_prime;
	logic               below_is_prime;
	logic               is_near_prime;
	logic [COUNT_W-1:0] near_total;

	npt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	npt_datapath #(
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.value          (s_tdata[VALUE_WIDTH-1:0]),
		.cmd            (cmd),
		.stat           (stat),
		.above_is_prime (above_is_prime),
		.below_is_prime (below_is_prime),
		.is_near_prime  (is_near_prime),
		.near_total     (near_total)
	);

	assign m_tdata = OUT_W'({near_total, is_near_prime, below_is_prime, above_is_prime});

endmodule

`default_nettype wire

### src/npt_datapath.sv
`default_nettype none

module npt_datapath #(
	parameter int unsigned VALUE_WIDTH = 32
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire  [VALUE_WIDTH-1:0]        value,
	input  wire  npt_pkg::npt_cmd_t       cmd,
	output npt_pkg::npt_stat_t            stat,
	output logic                          above_is_prime,
	output logic                          below_is_prime,
	output logic                          is_near_prime,
	output logic [npt_pkg::COUNT_W-1:0]   near_total
);
	import npt_pkg::*;

	// Candidates are one bit wider than the value so that +1 and -1 never wrap.
	localparam int unsigned CW   = VALUE_WIDTH + 1;
	localparam int unsigned DW   = CW / 2 + 2;
	localparam int unsigned SW   = CW + 1;
	localparam int unsigned CNTW = $clog2(CW + 1);

	logic [VALUE_WIDTH-1:0] value_q;
	logic [CW-1:0]          cand_q;
	logic [DW-1:0]          div_q;
	logic [SW-1:0]          sq_q;
	logic [DW-1:0]          rem_q;
	logic [CW-1:0]          dvd_q;
	logic [CNTW-1:0]        cnt_q;
	logic                   above_q;
	logic                   below_q;
	logic                   out_above_q;
	logic                   out_below_q;
	logic [COUNT_W-1:0]     near_count_q;

	logic [CW-1:0] value_ext;
	logic [CW-1:0] cand_next;
	logic [DW:0]   rem_shift;
	logic [DW-1:0] rem_next;
	logic          near_item;

	assign value_ext = {value_q[VALUE_WIDTH-1], value_q};
	assign cand_next = cmd.below ? value_ext - CW'(1) : value_ext + CW'(1);

	// One restoring step: bring in the next dividend bit, subtract if it fits.
	assign rem_shift = {rem_q, dvd_q[CW-1]};
	always_comb begin
		if (rem_shift >= {1'b0, div_q}) begin
			rem_next = DW'(rem_shift - {1'b0, div_q});
		end else begin
			rem_next = rem_shift[DW-1:0];
		end
	end

	assign stat.low_cand = $signed(cand_q) < $signed(CW'(2));
	assign stat.sq_gt    = sq_q > {1'b0, cand_q};
	assign stat.div_last = cnt_q == CNTW'(1);
	assign stat.rem_zero = rem_q == '0;

	assign near_item = above_q | below_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= value;
		end
		if (cmd.init_cand) begin
			cand_q <= cand_next;
			div_q  <= DW'(2);
			sq_q   <= SW'(4);
		end
		if (cmd.advance) begin
			// (d+1)^2 = d^2 + 2d + 1
			div_q <= div_q + DW'(1);
			sq_q  <= sq_q + SW'({div_q, 1'b1});
		end
		if (cmd.start_div) begin
			dvd_q <= cand_q;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			dvd_q <= {dvd_q[CW-2:0], 1'b0};
			rem_q <= rem_next;
		end
		if (cmd.mark) begin
			if (cmd.below) begin
				below_q <= cmd.prime;
			end else begin
				above_q <= cmd.prime;
			end
		end
		if (cmd.finish) begin
			out_above_q <= above_q;
			out_below_q <= below_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			near_count_q <= '0;
		end else begin
			if (cmd.start_div) begin
				cnt_q <= CNTW'(CW);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - CNTW'(1);
			end
			if (cmd.finish && near_item && near_count_q != COUNT_MAX) begin
				near_count_q <= near_count_q + COUNT_W'(1);
			end
		end
	end

	// The count only moves when a new result is loaded, so it serves as near_total.
	assign above_is_prime = out_above_q;
	assign below_is_prime = out_below_q;
	assign is_near_prime  = out_above_q | out_below_q;
	assign near_total     = near_count_q;

	a_rem_below_divisor: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> rem_q < div_q)
		else $error("remainder not below the trial divisor");

	a_count_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> near_count_q >= $past(near_count_q))
		else $error("near-prime count went down");

endmodule

`default_nettype wire

### src/npt_ctrl.sv
`default_nettype none

module npt_ctrl (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       s_tvalid,
	output logic                      s_tready,
	output logic                      m_tvalid,
	input  wire                       m_tready,
	input  wire  npt_pkg::npt_stat_t  stat,
	output npt_pkg::npt_cmd_t         cmd
);
	import npt_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE  = 6'b000001,
		S_CAND  = 6'b000010,
		S_CHECK = 6'b000100,
		S_DIV   = 6'b001000,
		S_TEST  = 6'b010000,
		S_OUT   = 6'b100000
	} npt_state_t;

	npt_state_t state_q, state_d;
	logic       below_q, below_d;
	logic       out_valid_q;
	logic       cand_done;

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d   = state_q;
		below_d   = below_q;
		cand_done = 1'b0;
		cmd       = '0;
		cmd.below = below_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					below_d  = 1'b0;
					state_d  = S_CAND;
				end
			end
			S_CAND: begin
				cmd.init_cand = 1'b1;
				state_d       = S_CHECK;
			end
			S_CHECK: begin
				if (stat.low_cand || stat.sq_gt) begin
					cmd.mark  = 1'b1;
					cmd.prime = !stat.low_cand;
					cand_done = 1'b1;
				end else begin
					cmd.start_div = 1'b1;
					state_d       = S_DIV;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_TEST;
				end
			end
			S_TEST: begin
				if (stat.rem_zero) begin
					cmd.mark  = 1'b1;
					cmd.prime = 1'b0;
					cand_done = 1'b1;
				end else begin
					cmd.advance = 1'b1;
					state_d     = S_CHECK;
				end
			end
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// After value+1 comes value-1, then the result.
		if (cand_done) begin
			if (below_q) begin
				state_d = S_OUT;
			end else begin
				below_d = 1'b1;
				state_d = S_CAND;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			below_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			below_q <= below_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_div_ends_in_test: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV && stat.div_last) |=> state_q == S_TEST)
		else $error("division did not end in the remainder test");

	a_finish_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_tready))
		else $error("result overwritten before it was taken");

endmodule

`default_nettype wire

### bench/near_prime_tester_test.sv
`timescale 1ns / 100ps

module near_prime_tester_test;

	import npt_pkg::*;

	localparam int unsigned VALUE_W     = 32;
	localparam int unsigned IN_W        = 32;
	localparam int unsigned CYCLE_LIMIT = 3_000_000;
	localparam int unsigned MAX_SHOWN   = 10;
	localparam int unsigned SETTLE      = 200;

	typedef struct {
		logic                above;
		logic                below;
		logic                near;
		logic [COUNT_W-1:0]  total;
	} verdict_t;

	logic              clk      = 1'b0;
	logic              arst_n   = 1'b0;
	logic              s_tvalid = 1'b0;
	logic [IN_W-1:0]   s_tdata  = '0;
	logic              m_tready = 1'b0;
	wire               s_tready;
	wire               m_tvalid;
	wire  [OUT_W-1:0]  m_tdata;

	verdict_t           pending_verdicts[$];
	logic [COUNT_W-1:0] near_tally = '0;
	int unsigned        sent_items      = 0;
	int unsigned        checked_results = 0;
	int unsigned        mismatches      = 0;
	int unsigned        near_seen       = 0;
	int unsigned        wide_values     = 0;
	int unsigned        cycles          = 0;
	bit                 tx_idle         = 1'b1;
	bit                 rx_idle         = 1'b1;

	near_prime_tester #(
		.VALUE_WIDTH(VALUE_W)
	) DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit is_prime_candidate(longint cand);
		longint d;
		if (cand <= 1)
			return 1'b0;
		for (d = 2; d * d <= cand; d++)
			if (cand % d == 0)
				return 1'b0;
		return 1'b1;
	endfunction

	// Works out the result of one accepted value and advances the saturating tally.
	function automatic verdict_t judge_value(logic [IN_W-1:0] raw);
		verdict_t v;
		longint   n;
		n = longint'($signed(raw[VALUE_W-1:0]));
		v.above = is_prime_candidate(n + 1);
		v.below = is_prime_candidate(n - 1);
		v.near  = v.above | v.below;
		if (v.near && near_tally != COUNT_MAX)
			near_tally++;
		v.total = near_tally;
		return v;
	endfunction

	task automatic send_value(input logic [IN_W-1:0] value);
		int unsigned gap;
		gap = tx_idle ? $urandom_range(0, 6) : 0;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		pending_verdicts.push_back(judge_value(value));
		sent_items++;
		if ($signed(value) > 65535 || $signed(value) < -65536)
			wide_values++;
	endtask

	task automatic hold_until_drained();
		s_tvalid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_small_neighbors();
		send_value(32'sd0);
		send_value(32'sd1);
		send_value(-32'sd1);
		send_value(-32'sd2);
		send_value(32'sd2);
		send_value(32'sd3);
		send_value(32'sd4);
		send_value(32'sd5);
		send_value(32'sd6);
		send_value(32'sd8);
		send_value(32'sd12);
		send_value(32'sd24);
	endtask

	// Odd positive extremes have even neighbors, negative ones neighbors below two: all settle quickly.
	task automatic test_field_extremes();
		send_value(32'h7FFF_FFFF);
		send_value(32'h8000_0000);
		send_value(32'h8000_0001);
		send_value(32'h5555_5555);
		send_value(32'hAAAA_AAAA);
		send_value(32'hFFFF_FFFE);
		send_value(32'h7FFF_FFFD);
	endtask

	task automatic test_large_neighbor();
		send_value(32'd1000002);
		send_value(32'd999984);
	endtask

	task automatic test_wait_for_drain();
		repeat (3) send_value(32'($urandom_range(0, 300)));
		hold_until_drained();
		tx_idle = 1'b0;
		repeat (3) send_value(32'($urandom_range(0, 300)));
		tx_idle = 1'b1;
	endtask

	task automatic test_random_mix();
		int               blk;
		int               i;
		int               small_val;
		logic [IN_W-1:0]  value;
		for (blk = 0; blk < 4; blk++) begin
			tx_idle = (blk % 4 == 0) || (blk % 4 == 2);
			rx_idle = (blk % 4 == 0) || (blk % 4 == 1);
			for (i = 0; i < 20; i++) begin
				case ($urandom_range(0, 9)) inside
					[0:4]: begin
						small_val = int'($urandom_range(0, 4146)) - 50;
						value = small_val;
					end
					5: begin
						small_val = int'($urandom_range(0, 23)) - 3;
						value = small_val;
					end
					6: value = $urandom() | 32'h1;
					// Values of the form 30k+4 have neighbors divisible by three and by five.
					7: value = 32'(30 * $urandom_range(0, 71582787) + 4);
					8: value = $urandom() | 32'h8000_0000;
					default: begin
						small_val = -int'($urandom_range(0, 2000));
						value = small_val;
					end
				endcase
				send_value(value);
			end
		end
		tx_idle = 1'b1;
		rx_idle = 1'b1;
	endtask

	initial begin
		int unsigned stall;
		@(posedge arst_n);
		forever begin
			stall = rx_idle ? $urandom_range(0, 6) : 0;
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && m_tvalid && m_tready) begin
			checked_results++;
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("Unexpected result transaction: data %h", m_tdata);
			end else begin
				want = pending_verdicts.pop_front();
				if (want.near)
					near_seen++;
				if (m_tdata[0] !== want.above || m_tdata[1] !== want.below ||
				    m_tdata[2] !== want.near || m_tdata[3 +: COUNT_W] !== want.total) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("Result %0d: above %b/%b below %b/%b near %b/%b total %0d/%0d",
							checked_results, want.above, m_tdata[0], want.below, m_tdata[1],
							want.near, m_tdata[2], want.total, m_tdata[3 +: COUNT_W]);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d results outstanding",
				cycles, pending_verdicts.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		test_small_neighbors();
		test_field_extremes();
		test_large_neighbor();
		test_wait_for_drain();
		test_random_mix();
		hold_until_drained();
		repeat (SETTLE) @(posedge clk);
		$display("Checked %0d results for %0d values, %0d of them near a prime, %0d wide.",
			checked_results, sent_items, near_seen, wide_values);
		$display("Covered small, negative and extreme values, large primes, stalls, a drain.");
		if (mismatches == 0 && pending_verdicts.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
